// ===== rtl/core/cra_pkg.sv =====
// Package for the compacting region allocator.
// Holds the slot table constants, the request and response structs and the codes.
// No dependencies.
`timescale 1ns / 1ps

package cra_pkg;

  // Slot table size and width of stored offsets.
  localparam int SLOTS     = 8;
  localparam int ADDR_BITS = 16;

  // Derived widths.
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int LEN_W  = 16;
  localparam int USED_W = LEN_W + $clog2(SLOTS);

  localparam logic [15:0] POOL_RESET = 16'd4096;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_ENSURE  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2
  } op_t;

  // Response codes.
  localparam logic KIND_MOVE      = 1'b0;
  localparam logic KIND_STATUS    = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NOSPACE = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  slot;
    logic [15:0] needed;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic        status;
    logic [15:0] move_src;
    logic [15:0] move_dst;
    logic [15:0] move_len;
    logic [15:0] region_offset;
    logic [15:0] used_bytes;
    logic        last;
  } rsp_t;

  // One slot table entry: offset and extent.
  typedef struct packed {
    logic [ADDR_BITS-1:0] off;
    logic [LEN_W-1:0]     ext;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_PICK,
    ST_MOVE,
    ST_REPLY
  } state_t;

endpackage

// ===== rtl/core/compacting_region_allocator.sv =====
// Compacting region allocator: top level with the slot table memory and sequencer.
// Depends on cra_pkg for types, codes and table size.
//
// Usage: requests enter on req_valid/req_stall with a req_t payload (op, slot,
// needed). Responses leave on rsp_valid/rsp_stall as rsp_t items. An ensure
// that must grow or create a region within the pool produces one move command per
// shifted member, in ascending offset order, followed by one final status with
// last set; every other request produces a single final status. The external mover
// must copy data in the order the moves are given.
// Steps: a request is taken in idle, its table entry is read and classified in the
// look state, and its status is loaded into the output register in the reply state.
// A compacting ensure makes one scan of the slot table per member plus one,
// each scan reading the table memory one entry a cycle, and issues each move
// from the move state before the next scan.
// The next request is taken only after the current one has handed over its
// final status to the output register, which may still be waiting.
// Reset clears all slot valid marks, the used byte count and the pool size to 4096;
// the table memory needs no clearing. While the receiver stalls, the output register
// holds its response and the sequencer waits before loading another. The pool size
// register must be written with cfg_wr_en/cfg_wr_data only while idle; unenforced.
`timescale 1ns / 1ps

module compacting_region_allocator
  import cra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  state_t state, state_next;

  // Slot table memory and registered read port.
  entry_t mem [SLOTS];
  entry_t rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;
  logic [IDX_W-1:0] mem_ra;

  logic [SLOTS-1:0]     slot_valid;
  logic [SLOTS-1:0]     done;
  logic [15:0]          pool;
  logic [USED_W-1:0]    used;
  req_t                 req_r;
  logic [ADDR_BITS-1:0] cursor;
  logic [CNT_W-1:0]     cnt;
  logic                 have;
  logic [IDX_W-1:0]     best_idx;
  logic [ADDR_BITS-1:0] best_off;
  logic [LEN_W-1:0]     best_ext;
  logic                 rep_nospace;
  logic [ADDR_BITS-1:0] rep_off;

  logic              out_free;
  logic              out_load;
  rsp_t              out_data;
  logic [IDX_W-1:0]  req_idx;
  logic              slot_ok;
  logic              cur_valid;
  logic [USED_W-1:0] others;
  logic [USED_W-1:0] others_plus;
  logic              lk_bypass, lk_free, lk_keep, lk_nofit, lk_compact;
  logic              scan_end;
  logic [IDX_W-1:0]  e_idx;
  logic              cand;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);
  assign req_idx   = IDX_W'(req_r.slot);
  assign slot_ok   = (int'(req_r.slot) < SLOTS);
  assign cur_valid = slot_valid[req_idx];

  // Classify the request once the addressed entry has been read.
  always_comb begin
    others      = used - (cur_valid ? USED_W'(rd_data.ext) : '0);
    others_plus = others + USED_W'(req_r.needed);
    lk_bypass   = !slot_ok || !((req_r.op == OP_ENSURE) || (req_r.op == OP_RELEASE));
    lk_free     = !lk_bypass && ((req_r.op == OP_RELEASE) || (req_r.needed == '0));
    lk_keep     = !lk_bypass && !lk_free && cur_valid && (req_r.needed <= rd_data.ext);
    lk_nofit    = !lk_bypass && !lk_free && !lk_keep && (others_plus > USED_W'(pool));
    lk_compact  = !lk_bypass && !lk_free && !lk_keep && !lk_nofit;
  end

  // Scan evaluation: the entry read in the previous cycle is a candidate
  // when it is a valid, unplaced member with the lowest offset so far.
  assign scan_end = (cnt == CNT_W'(SLOTS));
  assign e_idx    = IDX_W'(cnt - CNT_W'(1));
  assign cand     = (state == ST_SCAN) && (cnt != '0) && slot_valid[e_idx] &&
                    (e_idx != req_idx) && !done[e_idx] &&
                    (!have || (rd_data.off < best_off));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req_valid) state_next = ST_LOOK;
      ST_LOOK:  state_next = lk_compact ? ST_SCAN : ST_REPLY;
      ST_SCAN:  if (scan_end) state_next = ST_PICK;
      ST_PICK: begin
        if (!have) state_next = ST_REPLY;
        else if (best_off == cursor) state_next = ST_SCAN;
        else state_next = ST_MOVE;
      end
      ST_MOVE:  if (out_free) state_next = ST_SCAN;
      ST_REPLY: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory controls and response loading.
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = req_idx;
    mem_wd   = '{off: cursor, ext: req_r.needed};
    mem_ra   = '0;
    out_load = 1'b0;
    out_data = '0;
    case (state)
      ST_IDLE: mem_ra = IDX_W'(req.slot);
      ST_LOOK: begin
        if (lk_keep) begin
          mem_we = 1'b1;
          mem_wd = '{off: rd_data.off, ext: req_r.needed};
        end
      end
      ST_SCAN: begin
        if (cnt < CNT_W'(SLOTS)) mem_ra = IDX_W'(cnt);
      end
      ST_PICK: begin
        if (!have) mem_we = 1'b1;
      end
      ST_MOVE: begin
        if (out_free) begin
          mem_we   = 1'b1;
          mem_wa   = best_idx;
          mem_wd   = '{off: cursor, ext: best_ext};
          out_load = 1'b1;
          out_data.kind     = KIND_MOVE;
          out_data.status   = STATUS_OK;
          out_data.move_src = 16'(best_off);
          out_data.move_dst = 16'(cursor);
          out_data.move_len = 16'(best_ext);
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          out_load = 1'b1;
          out_data.kind          = KIND_STATUS;
          out_data.status        = rep_nospace ? STATUS_NOSPACE : STATUS_OK;
          out_data.region_offset = 16'(rep_off);
          out_data.used_bytes    = used[15:0];
          out_data.last          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Slot table memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      used       <= '0;
      pool       <= POOL_RESET;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) pool <= cfg_wr_data;
      if (out_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      case (state)
        ST_LOOK: begin
          if (lk_free && cur_valid) begin
            slot_valid[req_idx] <= 1'b0;
            used <= used - USED_W'(rd_data.ext);
          end else if (lk_keep) begin
            used <= others_plus;
          end else if (lk_compact) begin
            used <= others_plus;
          end
        end
        ST_PICK: begin
          if (!have) slot_valid[req_idx] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Request, scan and response payload registers.
  always_ff @(posedge clk) begin
    if (out_load) rsp <= out_data;
    case (state)
      ST_IDLE: begin
        if (req_valid) req_r <= req;
      end
      ST_LOOK: begin
        rep_nospace <= lk_nofit;
        rep_off     <= lk_keep ? rd_data.off : '0;
        done        <= '0;
        cursor      <= '0;
        cnt         <= '0;
      end
      ST_SCAN: begin
        if (cnt == '0) have <= 1'b0;
        if (cand) begin
          have     <= 1'b1;
          best_idx <= e_idx;
          best_off <= rd_data.off;
          best_ext <= rd_data.ext;
        end
        if (!scan_end) cnt <= cnt + CNT_W'(1);
      end
      ST_PICK: begin
        cnt <= '0;
        if (!have) begin
          rep_off <= cursor;
        end else begin
          done[best_idx] <= 1'b1;
          if (best_off == cursor) cursor <= cursor + ADDR_BITS'(best_ext);
        end
      end
      ST_MOVE: begin
        if (out_free) cursor <= cursor + ADDR_BITS'(best_ext);
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // A shifted member always carries data.
  a_move_len: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind == KIND_MOVE) |-> (rsp.move_len != '0))
    else $error("move command with zero length");

  // The requesting slot is never compacted as a member of its own request.
  a_pick_self: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK && have) |-> (best_idx != req_idx))
    else $error("requesting slot picked during compaction");

  // Compaction never runs past the end of the pool.
  a_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK) |-> (USED_W'(cursor) <= USED_W'(pool)))
    else $error("compaction cursor beyond pool size");

  // A move command is always followed by more results in the same request.
  a_move_then_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE && out_free) |=> (state == ST_SCAN && rsp.last == 1'b0))
    else $error("move command not followed by a new scan");
`endif

endmodule
